>>> sv/aes_pkg.sv
// Package for the AES-128 block cipher: types, S-box tables and GF(2^8) helpers.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package aes_pkg;

    localparam int RoundCount = 10;
    localparam int KeyWords   = 2 * (RoundCount + 1);
    localparam int RoundBits  = $clog2(RoundCount + 1);

    localparam logic [0:0] CfgKeyHigh = 1'b0;
    localparam logic [0:0] CfgKeyLow  = 1'b1;

    typedef logic [127:0] block_t;
    typedef logic [RoundBits-1:0] round_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_CRYPT,
        ST_DONE
    } aes_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic   load_block;
        logic   expand_step;
        logic   crypt_step;
        logic   first_round;
        logic   last_round;
        round_t round;
    } aes_cmd_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

endpackage

>>> sv/aes_ctrl.sv
// Controller for the AES-128 block cipher: sequences key expansion and rounds.
// Depends on aes_pkg for the state enum and the command struct.
`timescale 1ns / 1ps

module aes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              key_write,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output aes_pkg::aes_cmd_t cmd
);
    import aes_pkg::*;

    aes_state_t state_reg, state_next;
    round_t     round_reg, round_next;
    logic       keys_ready_reg, keys_ready_next;

    // State, round counter and key status registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            keys_ready_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            round_reg      <= round_next;
            keys_ready_reg <= keys_ready_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next      = state_reg;
        round_next      = round_reg;
        keys_ready_next = keys_ready_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd             = '0;
        cmd.round       = round_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_block = 1'b1;
                    if (keys_ready_reg) begin
                        state_next = ST_CRYPT;
                        round_next = round_t'(1);
                    end else begin
                        state_next = ST_EXPAND;
                        round_next = round_t'(1);
                    end
                end
            end
            ST_EXPAND: begin
                cmd.expand_step = 1'b1;
                if (round_reg == round_t'(RoundCount)) begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_CRYPT;
                    round_next      = round_t'(1);
                end else begin
                    round_next = round_reg + round_t'(1);
                end
            end
            ST_CRYPT: begin
                cmd.crypt_step  = 1'b1;
                cmd.first_round = (round_reg == round_t'(1));
                cmd.last_round  = (round_reg == round_t'(RoundCount));
                if (round_reg == round_t'(RoundCount)) begin
                    state_next = ST_DONE;
                end else begin
                    round_next = round_reg + round_t'(1);
                end
            end
            ST_DONE: begin
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (key_write) keys_ready_next = 1'b0;
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= round_t'(RoundCount))
        else $error("round counter out of range");
    a_ready_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input ready while a result waits");
    a_crypt_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRYPT) |-> keys_ready_reg)
        else $error("rounds run without expanded keys");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
`endif

endmodule

>>> sv/aes_datapath.sv
// Datapath for the AES-128 block cipher: key registers, round key memory,
// shared round unit and key schedule step. Depends on aes_pkg.
`timescale 1ns / 1ps

module aes_datapath (
    input  logic              aclk,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              key_write,
    input  logic              aresetn,
    input  aes_pkg::aes_cmd_t cmd,
    input  logic              in_action,
    input  aes_pkg::block_t   in_block,
    output aes_pkg::block_t   out_block
);
    import aes_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    block_t      state_reg;
    block_t      sched_reg;
    logic [7:0]  rcon_reg;
    logic        dec_reg;
    block_t      rk_mem [RoundCount + 1];
    block_t      rk_rd_reg;

    // Key registers, reset to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we && key_write) begin
            if (cfg_index == CfgKeyHigh) key_high_reg <= cfg_data;
            else                         key_low_reg  <= cfg_data;
        end
    end

    // Byte i of a 128-bit word sits at bits 127-8i down.
    function automatic logic [7:0] byte_of(input block_t w, input int i);
        byte_of = w[127-8*i -: 8];
    endfunction

    // One key schedule step.
    block_t sched_next;
    always_comb begin
        logic [7:0] t [4];
        logic [7:0] n [16];
        t[0] = SBOX[byte_of(sched_reg, 13)] ^ rcon_reg;
        t[1] = SBOX[byte_of(sched_reg, 14)];
        t[2] = SBOX[byte_of(sched_reg, 15)];
        t[3] = SBOX[byte_of(sched_reg, 12)];
        for (int i = 0; i < 4; i++) n[i] = byte_of(sched_reg, i) ^ t[i];
        for (int i = 4; i < 16; i++) n[i] = n[i-4] ^ byte_of(sched_reg, i);
        for (int i = 0; i < 16; i++) sched_next[127-8*i -: 8] = n[i];
    end

    // Round key address: read ahead for the next cycle's round.
    // Encryption walks keys 1 to 10, decryption walks keys 10 down to 1.
    round_t rd_addr;
    always_comb begin
        if (cmd.load_block || cmd.expand_step) begin
            rd_addr = (cmd.load_block ? in_action : dec_reg) ? round_t'(RoundCount)
                                                              : round_t'(1);
        end else if (!cmd.crypt_step || cmd.last_round) begin
            rd_addr = '0;
        end else begin
            rd_addr = dec_reg ? round_t'(RoundCount) - cmd.round
                              : cmd.round + round_t'(1);
        end
    end

    // Round key memory: one write port, one registered read port. A read of
    // the key being written in the same cycle takes the new value.
    always_ff @(posedge aclk) begin
        if (cmd.load_block) begin
            rk_mem[0] <= {key_high_reg, key_low_reg};
        end else if (cmd.expand_step) begin
            rk_mem[cmd.round] <= sched_next;
        end
        if (cmd.expand_step && rd_addr == cmd.round) begin
            rk_rd_reg <= sched_next;
        end else begin
            rk_rd_reg <= rk_mem[rd_addr];
        end
    end

    // Round unit: forward or inverse round on the state.
    block_t round_out;
    always_comb begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        logic [7:0] o [16];
        for (int i = 0; i < 16; i++) s[i] = byte_of(state_reg, i);
        if (!dec_reg) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[r+4*c] = SBOX[s[r + 4*((c+r)&3)]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    m[4*c+r] = gmul(t[4*c+r], 4'd2) ^ gmul(t[4*c+((r+1)&3)], 4'd3)
                             ^ t[4*c+((r+2)&3)] ^ t[4*c+((r+3)&3)];
            for (int i = 0; i < 16; i++)
                o[i] = (cmd.last_round ? t[i] : m[i]) ^ byte_of(rk_rd_reg, i);
        end else begin
            // Inverse order: key add, inverse mix (skipped first), inverse sub/shift.
            for (int i = 0; i < 16; i++) t[i] = s[i] ^ byte_of(rk_rd_reg, i);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    m[4*c+r] = gmul(t[4*c+r], 4'd14) ^ gmul(t[4*c+((r+1)&3)], 4'd11)
                             ^ gmul(t[4*c+((r+2)&3)], 4'd13) ^ gmul(t[4*c+((r+3)&3)], 4'd9);
            if (cmd.first_round)
                for (int i = 0; i < 16; i++) m[i] = t[i];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    o[r + 4*((c+r)&3)] = ISBOX[m[r+4*c]];
        end
        for (int i = 0; i < 16; i++) round_out[127-8*i -: 8] = o[i];
    end

    // State, schedule and round constant registers. Round key 0 is the key
    // itself, so encryption whitening is applied as the block is loaded and
    // decryption whitening on the last round, both from the key registers;
    // the user must hold them still while an item is in flight; unenforced.
    always_ff @(posedge aclk) begin
        if (cmd.load_block) begin
            dec_reg   <= in_action;
            state_reg <= in_action ? in_block : (in_block ^ {key_high_reg, key_low_reg});
            sched_reg <= {key_high_reg, key_low_reg};
            rcon_reg  <= 8'h01;
        end else if (cmd.expand_step) begin
            sched_reg <= sched_next;
            rcon_reg  <= xtime(rcon_reg);
        end else if (cmd.crypt_step) begin
            if (cmd.last_round && dec_reg)
                state_reg <= round_out ^ {key_high_reg, key_low_reg};
            else
                state_reg <= round_out;
        end
    end

    assign out_block = state_reg;

endmodule

>>> sv/aes128_block_cipher.sv
// Top level of the AES-128 block cipher: stream ports, config port, controller
// and datapath. Depends on aes_pkg, aes_ctrl and aes_datapath.
//
//   channel   direction  payload
//   s_axis    in         tuser = action, tdata = {block_low, block_high}
//   m_axis    out        tdata = {result_low, result_high}
//   cfg       in         index 0 key_high, index 1 key_low
//
// An item is accepted, runs its rounds through the shared round unit, then
// waits at the output; after a key write the first item runs the key
// schedule before its rounds. Reset clears control and the key to zero.
// A stalled result holds the block; no new item enters until it is taken.
`timescale 1ns / 1ps

module aes128_block_cipher (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,   // block_high [63:0], block_low [127:64]
    input  logic           s_axis_tuser,   // action [0]
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [127:0]   m_axis_tdata,   // result_high [63:0], result_low [127:64]
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [63:0]    cfg_data
);
    import aes_pkg::*;

    aes_cmd_t cmd;
    block_t   blk_in, blk_out;
    logic     key_write;

    assign key_write = cfg_we;
    assign blk_in    = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign m_axis_tdata = {blk_out[63:0], blk_out[127:64]};

    aes_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_write (key_write),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    aes_datapath u_dp (
        .aclk      (aclk),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_write (key_write),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_action (s_axis_tuser),
        .in_block  (blk_in),
        .out_block (blk_out)
    );

endmodule

>>> tb/tb_aes128_block_cipher.sv
// Self-checking testbench for aes128_block_cipher: directed table, then random traffic.
// Carries its own AES-128 key schedule and cipher for prediction; needs aes_pkg and the RTL.
`timescale 1ns / 1ps

module tb_aes128_block_cipher;
    import aes_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int DrainCycles = 40;

    typedef struct packed {
        logic        key_set;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        action;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic        known;
        logic [63:0] want_hi;
        logic [63:0] want_lo;
    } vector_row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;   // block_high [63:0], block_low [127:64]
    logic          s_axis_tuser = 1'b0; // action [0]
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [127:0]  m_axis_tdata;        // result_high [63:0], result_low [127:64]
    logic          cfg_we = 1'b0;
    logic          cfg_index = 1'b0;
    logic [63:0]   cfg_data = '0;

    logic [127:0]  cipher_out_q [$];
    logic [127:0]  round_keys [11];
    logic [127:0]  cur_key = '0;
    int            src_idle = 0;
    int            sink_stall = 0;
    int            errors = 0;
    int            cycles = 0;

    aes128_block_cipher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // GF(2^8) arithmetic with the AES polynomial.
    function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] gf_reciprocal(logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r = 8'h01;
        base = a;
        e = 8'hfe;
        // a^254 by square and multiply, which maps zero to zero.
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = gf_product(r, base);
            base = gf_product(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rot8(logic [7:0] b, int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_fwd(logic [7:0] b);
        logic [7:0] x;
        x = gf_reciprocal(b);
        return x ^ rot8(x, 1) ^ rot8(x, 2) ^ rot8(x, 3) ^ rot8(x, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] sbox_inv(logic [7:0] b);
        return gf_reciprocal(rot8(b, 1) ^ rot8(b, 3) ^ rot8(b, 6) ^ 8'h05);
    endfunction

    // Byte i of a block sits in the top bits first.
    function automatic logic [7:0] byte_at(logic [127:0] s, int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic void build_round_keys(logic [127:0] key);
        logic [127:0] k;
        logic [127:0] n;
        logic [7:0]   rc;
        k = key;
        rc = 8'h01;
        round_keys[0] = key;
        for (int r = 1; r <= 10; r++) begin
            n[127 -: 8] = byte_at(k, 0) ^ sbox_fwd(byte_at(k, 13)) ^ rc;
            n[119 -: 8] = byte_at(k, 1) ^ sbox_fwd(byte_at(k, 14));
            n[111 -: 8] = byte_at(k, 2) ^ sbox_fwd(byte_at(k, 15));
            n[103 -: 8] = byte_at(k, 3) ^ sbox_fwd(byte_at(k, 12));
            for (int i = 4; i < 16; i++)
                n[127 - 8 * i -: 8] = byte_at(n, i - 4) ^ byte_at(k, i);
            k = n;
            round_keys[r] = k;
            rc = gf_product(rc, 8'h02);
        end
    endfunction

    // SubBytes and ShiftRows together, forward or inverse.
    function automatic logic [127:0] sub_rows(logic [127:0] s, logic inv);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (inv)
                    t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = sbox_inv(byte_at(s, r + 4 * c));
                else
                    t[127 - 8 * (r + 4 * c) -: 8] = sbox_fwd(byte_at(s, r + 4 * ((c + r) & 3)));
            end
        return t;
    endfunction

    function automatic logic [127:0] column_mix(logic [127:0] s, logic inv);
        logic [7:0]   coef [4];
        logic [7:0]   v;
        logic [127:0] t;
        if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int j = 0; j < 4; j++)
                    v = v ^ gf_product(byte_at(s, 4 * c + j), coef[(j - r + 4) & 3]);
                t[127 - 8 * (4 * c + r) -: 8] = v;
            end
        return t;
    endfunction

    function automatic logic [127:0] aes_cipher(logic [127:0] s, logic decrypt);
        if (!decrypt) begin
            s = s ^ round_keys[0];
            for (int r = 1; r <= 10; r++) begin
                s = sub_rows(s, 1'b0);
                if (r != 10) s = column_mix(s, 1'b0);
                s = s ^ round_keys[r];
            end
        end else begin
            for (int r = 10; r >= 1; r--) begin
                s = s ^ round_keys[r];
                if (r != 10) s = column_mix(s, 1'b1);
                s = sub_rows(s, 1'b1);
            end
            s = s ^ round_keys[0];
        end
        return s;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Result side: random back-pressure and in-order comparison.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (cipher_out_q.size() == 0) begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                logic [127:0] want;
                want = cipher_out_q.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64]) begin
                    $error("result_high expected %h actual %h", want[127:64], m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== want[63:0]) begin
                    $error("result_low expected %h actual %h", want[63:0], m_axis_tdata[127:64]);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb_aes128_block_cipher: FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (cipher_out_q.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Writes both key registers; only called while the block is idle.
    task automatic load_key(logic [127:0] key);
        cfg_we    <= 1'b1;
        cfg_index <= CfgKeyHigh;
        cfg_data  <= key[127:64];
        @(posedge aclk);
        cfg_index <= CfgKeyLow;
        cfg_data  <= key[63:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_key = key;
        build_round_keys(cur_key);
    endtask

    // Presents one item and waits for the handshake; queues its expected result.
    task automatic send_block(logic decrypt, logic [127:0] blk, logic known,
                              logic [127:0] want);
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= decrypt;
        s_axis_tdata  <= {blk[63:0], blk[127:64]};
        do @(posedge aclk); while (!s_axis_tready);
        cipher_out_q.push_back(known ? want : aes_cipher(blk, decrypt));
    endtask

    vector_row_t vectors [14] = '{
        // Reset key: all-zero block and its inverse, then all-ones and single-bit blocks.
        '{1'b0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0,
          1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
        '{1'b0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e,
          1'b1, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b0, '1, '1, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b1, '1, '1, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b0, 64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b1, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
        // Standard published vector.
        '{1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b0,
          64'h0011223344556677, 64'h8899aabbccddeeff,
          1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
        '{1'b0, 64'h0, 64'h0, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
          1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff},
        '{1'b0, 64'h0, 64'h0, 1'b0, '1, '1, 1'b0, 64'h0, 64'h0},
        // All-ones key.
        '{1'b1, '1, '1, 1'b0, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b0, '1, '1, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 1'b1, '1, '1, 1'b0, 64'h0, 64'h0},
        // Back to the zero key, written explicitly.
        '{1'b1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0,
          1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}
    };

    initial begin
        int stall_cfg [4] = '{0, 45, 0, 20};
        int idle_cfg  [4] = '{0, 0, 45, 20};
        logic [127:0] key;

        build_round_keys(cur_key);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        foreach (vectors[i]) begin
            if (vectors[i].key_set) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                load_key({vectors[i].key_hi, vectors[i].key_lo});
            end
            send_block(vectors[i].action, {vectors[i].blk_hi, vectors[i].blk_lo},
                       vectors[i].known, {vectors[i].want_hi, vectors[i].want_lo});
        end

        // Hold off until every result is back.
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // Random traffic over back-pressure and idling phases and several keys each.
        for (int p = 0; p < 4; p++) begin
            sink_stall = stall_cfg[p];
            src_idle   = idle_cfg[p];
            for (int k = 0; k < 4; k++) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                case (k)
                    0: key = '0;
                    1: key = '1;
                    default: key = rand128();
                endcase
                load_key(key);
                for (int n = 0; n < 103; n++) begin
                    case ($urandom_range(9))
                        0: send_block(1'($urandom_range(1)), '0, 1'b0, '0);
                        1: send_block(1'($urandom_range(1)), '1, 1'b0, '0);
                        default: send_block(1'($urandom_range(1)), rand128(), 1'b0, '0);
                    endcase
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_idle();
        if (errors == 0 && cipher_out_q.size() == 0) begin
            $display("tb_aes128_block_cipher: PASS");
        end else begin
            $display("tb_aes128_block_cipher: FAIL");
        end
        $finish;
    end

endmodule
